// File: design/cstp_pkg.sv
// ----------------------------------------------------------------------------
// cstp_pkg - shared definitions for the integer text parser
// Field widths, character codes, parser phases and character class helpers.
// ----------------------------------------------------------------------------
package cstp_pkg;

    localparam int MAX_STRING_LEN = 4096;
    localparam int POS_W          = $clog2(MAX_STRING_LEN);
    localparam int CH_W           = 8;
    localparam int VALUE_W        = 32;
    localparam int OFFSET_W       = 12;
    localparam int MAG_W          = 31;
    localparam int PROD_W         = MAG_W + 5;

    localparam logic [MAG_W-1:0] MAG_LIMIT = 31'o17777777777;
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_STRING_LEN - 1);

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UF    = 8'h46;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LF    = 8'h66;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;

    typedef enum logic [5:0] {
        PH_SEEK  = 6'b000001,
        PH_SIGN  = 6'b000010,
        PH_ZERO  = 6'b000100,
        PH_DIGS  = 6'b001000,
        PH_TRAIL = 6'b010000,
        PH_DONE  = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        RAD_DEC = 2'd0,
        RAD_OCT = 2'd1,
        RAD_HEX = 2'd2
    } t_radix;

    function automatic logic is_dec(input logic [CH_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// File: design/cstp_if.sv
// ----------------------------------------------------------------------------
// cstp_if - stream channels of the integer text parser
// Character channel into the parser and result channel out of it.
// ----------------------------------------------------------------------------
interface cstp_char_if;
    import cstp_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface cstp_result_if;
    import cstp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;
    logic                       rest_valid;
    logic [OFFSET_W-1:0]        rest_offset;
    logic                       overflow;

    modport source (output valid, output value, output rest_valid,
                    output rest_offset, output overflow, input ready);
    modport sink   (input valid, input value, input rest_valid,
                    input rest_offset, input overflow, output ready);
endinterface

// File: design/c_style_integer_text_parser.sv
// ----------------------------------------------------------------------------
// c_style_integer_text_parser - streaming signed integer text parser
// Parses one C-style integer (decimal, octal, hex) per NUL-ended string.
// ----------------------------------------------------------------------------
// Usage:
//   i_char carries one character per beat; a NUL beat ends the string and
//   re-arms the parser for the next one. o_result carries at most one beat
//   per string: the signed value, whether a rest of the string follows and
//   its offset from the string start, and an overflow flag.
//   A result is given at the first non-space character after the digits,
//   at once on magnitude overflow (saturated, no rest), or at NUL if the
//   string ended before either. Characters after a result are ignored.
// Flow:
//   One character per cycle while no result stall holds the input. A
//   character is held in the input register, then its result (if any)
//   sits in the output register.
// Reset and stalls:
//   i_rst_n clears the parse state and both register valid flags.
//   While o_result is stalled with a result waiting, characters that give
//   no result keep flowing; one that would give a result holds in the
//   input register, and i_char.ready drops until the output slot frees.
// ----------------------------------------------------------------------------
module c_style_integer_text_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    cstp_char_if.sink               i_char,
    cstp_result_if.source           o_result
);
    import cstp_pkg::*;

    // input register
    logic                   r_in_valid;
    logic [CH_W-1:0]        r_ch;

    // parse state
    t_phase                 r_phase,  n_phase;
    t_radix                 r_radix,  n_radix;
    logic                   r_neg,    n_neg;
    logic [MAG_W-1:0]       r_acc,    n_acc;
    logic [POS_W-1:0]       r_pos,    n_pos;

    // result register
    logic                   r_out_valid;
    logic [VALUE_W-1:0]     r_value;
    logic                   r_rest_valid;
    logic [OFFSET_W-1:0]    r_rest_offset;
    logic                   r_overflow;

    // step outputs
    logic                   has_res;
    logic [MAG_W-1:0]       res_mag;
    logic                   res_rest;
    logic                   res_ovf;
    logic                   consume;

    // digit evaluation
    t_radix                 dig_radix;
    logic                   d_ok;
    logic [3:0]             d_val;
    logic [PROD_W-1:0]      prod;
    logic                   d_ovf;
    logic                   run_dig;
    logic                   run_trail;

    // Radix in force when the current character reaches the digit stage.
    always_comb begin
        if (r_phase == PH_ZERO) begin
            dig_radix = RAD_OCT;
        end else if (r_phase == PH_DIGS) begin
            dig_radix = r_radix;
        end else begin
            dig_radix = RAD_DEC;
        end
    end

    // Digit value; octal still takes 8 and 9.
    always_comb begin
        d_ok  = 1'b0;
        d_val = 4'd0;
        if (is_dec(r_ch)) begin
            d_ok  = 1'b1;
            d_val = 4'(r_ch - CH_0);
        end else if (dig_radix == RAD_HEX) begin
            if ((r_ch >= CH_UA) && (r_ch <= CH_UF)) begin
                d_ok  = 1'b1;
                d_val = 4'(r_ch - CH_UA + 8'd10);
            end else if ((r_ch >= CH_LA) && (r_ch <= CH_LF)) begin
                d_ok  = 1'b1;
                d_val = 4'(r_ch - CH_LA + 8'd10);
            end
        end
    end

    // Shift-add by the base; the magnitude never exceeds 31 bits, so 36 hold it.
    always_comb begin
        case (dig_radix)
            RAD_HEX: prod = {1'b0, r_acc, 4'b0000};
            RAD_OCT: prod = {2'b00, r_acc, 3'b000};
            default: prod = {2'b00, r_acc, 3'b000} + {4'b0000, r_acc, 1'b0};
        endcase
        prod  = prod + PROD_W'(d_val);
        d_ovf = prod > PROD_W'(MAG_LIMIT);
    end

    // Phase step for the character in the input register.
    always_comb begin
        n_phase   = r_phase;
        n_radix   = r_radix;
        n_neg     = r_neg;
        n_acc     = r_acc;
        has_res   = 1'b0;
        res_mag   = r_acc;
        res_rest  = 1'b0;
        res_ovf   = 1'b0;
        run_dig   = 1'b0;
        run_trail = 1'b0;

        if (r_ch == CH_NUL) begin
            // End of string: report if nothing was reported yet, then re-arm.
            has_res = (r_phase != PH_DONE);
            n_phase = PH_SEEK;
            n_radix = RAD_DEC;
            n_neg   = 1'b0;
            n_acc   = '0;
        end else begin
            unique case (r_phase)
                PH_SEEK: begin
                    if (r_ch == CH_PLUS) begin
                        n_phase = PH_SIGN;
                    end else if (r_ch == CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_SIGN;
                    end else if (r_ch == CH_0) begin
                        n_radix = RAD_OCT;
                        n_phase = PH_ZERO;
                    end else if (is_dec(r_ch)) begin
                        n_radix = RAD_DEC;
                        run_dig = 1'b1;
                    end
                end
                PH_SIGN: begin
                    if (r_ch == CH_0) begin
                        n_radix = RAD_OCT;
                        n_phase = PH_ZERO;
                    end else begin
                        n_radix = RAD_DEC;
                        run_dig = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if ((r_ch == CH_LX) || (r_ch == CH_UX)) begin
                        n_radix = RAD_HEX;
                        n_phase = PH_DIGS;
                    end else begin
                        run_dig = 1'b1;
                    end
                end
                PH_DIGS:  run_dig   = 1'b1;
                PH_TRAIL: run_trail = 1'b1;
                PH_DONE:  ;
                default:  ;
            endcase

            if (run_dig) begin
                if (!d_ok) begin
                    run_trail = 1'b1;
                end else if (d_ovf) begin
                    // Saturate and drop the rest of the string.
                    has_res = 1'b1;
                    res_mag = MAG_LIMIT;
                    res_ovf = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_acc   = prod[MAG_W-1:0];
                    n_phase = PH_DIGS;
                end
            end

            if (run_trail) begin
                if (is_space(r_ch)) begin
                    n_phase = PH_TRAIL;
                end else begin
                    has_res  = 1'b1;
                    res_rest = 1'b1;
                    n_phase  = PH_DONE;
                end
            end
        end
    end

    // Offset of the next character; saturate on very long strings.
    always_comb begin
        if (r_ch == CH_NUL) begin
            n_pos = '0;
        end else if (r_pos < POS_LAST) begin
            n_pos = r_pos + 1'b1;
        end else begin
            n_pos = r_pos;
        end
    end

    // Advance the held character unless its result would overrun a stalled slot.
    assign consume      = r_in_valid && (!has_res || !r_out_valid || o_result.ready);
    assign i_char.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_ch <= i_char.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_radix <= RAD_DEC;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_pos   <= '0;
        end else if (consume) begin
            r_phase <= n_phase;
            r_radix <= n_radix;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && has_res) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Apply the sign taken from the state before this beat.
    always_ff @(posedge i_clk) begin
        if (consume && has_res) begin
            r_value       <= r_neg ? (VALUE_W'(0) - VALUE_W'(res_mag)) : VALUE_W'(res_mag);
            r_rest_valid  <= res_rest;
            r_rest_offset <= res_rest ? OFFSET_W'(r_pos) : '0;
            r_overflow    <= res_ovf;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.value       = r_value;
    assign o_result.rest_valid  = r_rest_valid;
    assign o_result.rest_offset = r_rest_offset;
    assign o_result.overflow    = r_overflow;

endmodule

// File: test/tb_c_style_integer_text_parser.sv
// ----------------------------------------------------------------------------
// tb_c_style_integer_text_parser - self-checking bench for the text parser
// Streams NUL-ended strings into the parser: a directed set of corner cases,
// then random strings, most of them well-formed numbers with random content
// and some noise. A scoreboard predicts each result from the characters
// accepted and checks every result beat field by field.
// ----------------------------------------------------------------------------
module tb_c_style_integer_text_parser;
    import cstp_pkg::*;

    // Run length guard, in clock cycles
    localparam int CYCLE_LIMIT = 400000;
    // Idle odds per cycle on either side, in percent
    localparam int IDLE_PCT    = 21;
    // Length of the forced result stall
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      rest_valid;
        logic [OFFSET_W-1:0]       rest_offset;
        logic                      overflow;
    } t_parse_res;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the parse of the current string and queues the
    // result that each accepted character gives, if any.
    // ------------------------------------------------------------------------
    class int_parse_scoreboard;
        t_phase            phase;
        logic              neg;
        t_radix            radix;
        logic [31:0]       mag;
        logic [POS_W-1:0]  pos;
        t_parse_res        awaited[$];
        int                errors;

        function new();
            rearm();
            errors = 0;
        endfunction

        function void rearm();
            phase = PH_SEEK;
            neg   = 1'b0;
            radix = RAD_DEC;
            mag   = '0;
            pos   = '0;
        endfunction

        function bit is_digit(logic [CH_W-1:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function t_parse_res shape(logic [31:0] m, logic rv, logic [OFFSET_W-1:0] off,
                                   logic ovf);
            t_parse_res r;
            r.value       = neg ? -m : m;
            r.rest_valid  = rv;
            r.rest_offset = rv ? off : '0;
            r.overflow    = ovf;
            return r;
        endfunction

        // Advance the parse by one character; return 1 when it gives a result
        function bit advance(input logic [CH_W-1:0] c, output t_parse_res r);
            logic [OFFSET_W-1:0] here;
            logic [63:0]         prod;
            logic [4:0]          base;
            logic [4:0]          d;
            bit                  ok;
            bit                  again;
            bit                  got;
            here = pos;
            got  = 1'b0;
            r    = shape('0, 1'b0, '0, 1'b0);
            if (c == CH_NUL) begin
                // NUL gives the pending result unless one has gone already
                if (phase != PH_DONE) begin
                    r   = shape(mag, 1'b0, '0, 1'b0);
                    got = 1'b1;
                end
                rearm();
                return got;
            end
            again = 1'b1;
            while (again) begin
                again = 1'b0;
                case (phase)
                    PH_SEEK: begin
                        if (c == CH_PLUS) begin
                            phase = PH_SIGN;
                        end else if (c == CH_MINUS) begin
                            neg   = 1'b1;
                            phase = PH_SIGN;
                        end else if (is_digit(c)) begin
                            phase = PH_SIGN;
                            again = 1'b1;
                        end
                    end
                    PH_SIGN: begin
                        if (c == CH_0) begin
                            radix = RAD_OCT;
                            phase = PH_ZERO;
                        end else begin
                            radix = RAD_DEC;
                            phase = PH_DIGS;
                            again = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        if (c == CH_LX || c == CH_UX) begin
                            radix = RAD_HEX;
                        end else begin
                            again = 1'b1;
                        end
                        phase = PH_DIGS;
                    end
                    PH_DIGS: begin
                        ok = 1'b1;
                        d  = '0;
                        if (is_digit(c)) begin
                            d = 5'(c - CH_0);
                        end else if (radix == RAD_HEX && c >= CH_UA && c <= CH_UF) begin
                            d = 5'(c - CH_UA + 10);
                        end else if (radix == RAD_HEX && c >= CH_LA && c <= CH_LF) begin
                            d = 5'(c - CH_LA + 10);
                        end else begin
                            ok = 1'b0;
                        end
                        case (radix)
                            RAD_HEX: base = 5'd16;
                            RAD_OCT: base = 5'd8;
                            default: base = 5'd10;
                        endcase
                        if (!ok) begin
                            phase = PH_TRAIL;
                            again = 1'b1;
                        end else begin
                            prod = 64'(mag) * 64'(base) + 64'(d);
                            if (prod > 64'(MAG_LIMIT)) begin
                                r     = shape(32'(MAG_LIMIT), 1'b0, '0, 1'b1);
                                got   = 1'b1;
                                phase = PH_DONE;
                            end else begin
                                mag = prod[31:0];
                            end
                        end
                    end
                    PH_TRAIL: begin
                        if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                            r     = shape(mag, 1'b1, here, 1'b0);
                            got   = 1'b1;
                            phase = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            // Position sticks at the last offset on overlong strings
            if (pos != POS_LAST) pos++;
            return got;
        endfunction

        function void take_char(logic [CH_W-1:0] c);
            t_parse_res r;
            if (advance(c, r)) awaited.push_back(r);
        endfunction

        function void flag(string what, longint want, longint got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        endfunction

        function void match_result(t_parse_res got);
            t_parse_res want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %0d",
                         $time, got.value);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.value !== want.value)
                flag("value", want.value, got.value);
            if (got.rest_valid !== want.rest_valid)
                flag("rest_valid", want.rest_valid, got.rest_valid);
            if (got.rest_offset !== want.rest_offset)
                flag("rest_offset", want.rest_offset, got.rest_offset);
            if (got.overflow !== want.overflow)
                flag("overflow", want.overflow, got.overflow);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cstp_char_if   chr ();
    cstp_result_if res ();

    c_style_integer_text_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (chr),
        .o_result (res)
    );

    int_parse_scoreboard sb;

    logic [CH_W-1:0] line_buf[$];
    int              items_sent;
    int              cycles = 0;
    bit              calm;
    bit              hold_req;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Timeout guard: count cycles and give up well past the slowest run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_c_style_integer_text_parser NOT OK");
            $finish;
        end
    end

    // Monitor: sample both channels at the edge. Check the result beat
    // first; a character accepted at this edge cannot yet have a result.
    always @(posedge i_clk) begin
        t_parse_res got;
        if (i_rst_n) begin
            if (res.valid === 1'b1 && res.ready === 1'b1) begin
                got.value       = res.value;
                got.rest_valid  = res.rest_valid;
                got.rest_offset = res.rest_offset;
                got.overflow    = res.overflow;
                sb.match_result(got);
            end
            if (chr.valid === 1'b1 && chr.ready === 1'b1)
                sb.take_char(chr.ch);
        end
    end

    // Result side: random back-pressure, a calm stretch on request, and one
    // long hold-off so that the parser fills up and stalls its input.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                res.ready <= 1'b0;
            end else begin
                res.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
            @(posedge i_clk);
        end
    end

    // Offer one character and hold it until the beat is taken. Random idle
    // cycles go before the beat, except during the calm stretch.
    task automatic send_char(input logic [CH_W-1:0] c);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            chr.valid <= 1'b0;
            do @(posedge i_clk); while (!calm && $urandom_range(99) < IDLE_PCT);
        end
        chr.valid <= 1'b1;
        chr.ch    <= c;
        do @(posedge i_clk); while (chr.ready !== 1'b1);
    endtask

    // Send the buffered line and its NUL
    task automatic send_line();
        foreach (line_buf[i]) send_char(line_buf[i]);
        send_char(CH_NUL);
        items_sent += line_buf.size() + 1;
        line_buf.delete();
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic say(input string s);
        put_str(s);
        send_line();
    endtask

    // Any non-NUL byte that cannot open a number
    function automatic logic [CH_W-1:0] lead_junk();
        logic [CH_W-1:0] c;
        do c = CH_W'($urandom_range(1, 255));
        while ((c >= CH_0 && c <= CH_9) || c == CH_PLUS || c == CH_MINUS);
        return c;
    endfunction

    function automatic logic [CH_W-1:0] blank_char();
        logic [2:0] k;
        k = 3'($urandom_range(0, 5));
        return (k == 3'd5) ? CH_SPACE : CH_TAB + CH_W'(k);
    endfunction

    // Build one random string in line_buf
    task automatic make_random_line();
        string hexset;
        int    kind;
        int    rad;
        int    ndig;
        bit    big;
        hexset = "0123456789abcdefABCDEF";
        kind   = $urandom_range(99);
        if (kind < 12) begin
            // Noise: arbitrary bytes
            repeat ($urandom_range(0, 8)) line_buf.push_back(CH_W'($urandom_range(1, 255)));
            return;
        end
        if (kind < 22) begin
            // Broken shapes: bare sign, bare prefix, sign or prefix then text
            case ($urandom_range(0, 3))
                0: line_buf.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                1: put_str($urandom_range(1) ? "0x" : "0X");
                2: put_str($urandom_range(1) ? "-0x" : "+");
                default: put_str("0");
            endcase
            repeat ($urandom_range(0, 3)) line_buf.push_back(lead_junk());
            return;
        end
        // Well-formed: junk, sign, prefix, digits, blanks, tail
        repeat ($urandom_range(0, 3)) line_buf.push_back(lead_junk());
        case ($urandom_range(0, 2))
            1: line_buf.push_back(CH_PLUS);
            2: line_buf.push_back(CH_MINUS);
            default: ;
        endcase
        big = ($urandom_range(99) < 15);
        rad = $urandom_range(0, 2);
        if ($urandom_range(99) < 5) begin
            // Right at the saturation edge
            case ($urandom_range(0, 3))
                0: put_str("2147483647");
                1: put_str("2147483648");
                2: put_str("0x7fffffff");
                default: put_str("0X80000000");
            endcase
        end else if (rad == 0) begin
            ndig = big ? $urandom_range(10, 13) : $urandom_range(1, 9);
            line_buf.push_back(CH_0 + CH_W'($urandom_range(1, 9)));
            repeat (ndig - 1) line_buf.push_back(CH_0 + CH_W'($urandom_range(0, 9)));
        end else if (rad == 1) begin
            ndig = big ? $urandom_range(11, 13) : $urandom_range(0, 10);
            line_buf.push_back(CH_0);
            repeat (ndig) line_buf.push_back(CH_0 + CH_W'($urandom_range(0, 9)));
        end else begin
            ndig = big ? $urandom_range(8, 10) : $urandom_range(1, 7);
            put_str($urandom_range(1) ? "0x" : "0X");
            repeat (ndig) line_buf.push_back(hexset[$urandom_range(0, 21)]);
        end
        repeat ($urandom_range(0, 3)) line_buf.push_back(blank_char());
        if ($urandom_range(99) < 60)
            repeat ($urandom_range(1, 4)) line_buf.push_back(CH_W'($urandom_range(1, 255)));
    endtask

    initial begin
        int nstr;
        sb         = new();
        items_sent = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        i_rst_n   <= 1'b0;
        chr.valid <= 1'b0;
        chr.ch    <= CH_NUL;
        repeat (2) @(posedge i_clk);
        i_rst_n   <= 1'b1;

        // Directed corner cases
        say("");                        // empty string
        say("abc");                     // no number at all
        say("-");                       // sign alone
        say("+z");                      // sign then text
        say("0x");                      // hex prefix, no digits
        say("0Xg");                     // hex prefix, then text
        say("  -123  rest");
        say("+0");                      // lone zero reads as octal
        say("0777");
        say("089");                     // octal still takes 8 and 9
        say("0xFfAa0");
        say("2147483647 ");             // largest value, rest is null
        say("2147483648");              // just over the limit
        say("-2147483648x");
        say("0x7FFFFFFF\011\012\013\014\015 q");
        say("0x80000000");
        say("017777777777");
        say("020000000000");
        say("99999999999999 tail");     // overflow, later digits ignored
        say("12a more text");           // text after the result is dropped
        say("\377\200\177 9\377");      // high bytes around a number

        // Random strings; one long result stall early, one calm stretch
        nstr = 0;
        while (items_sent < 700) begin
            if (nstr == 4) hold_req = 1'b1;
            calm = (nstr >= 25 && nstr < 40);
            make_random_line();
            send_line();
            nstr++;
        end
        chr.valid <= 1'b0;

        // Drain: wait for every awaited result, then watch for stray results
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_c_style_integer_text_parser OK");
        end else begin
            $display("tb_c_style_integer_text_parser NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
design/cstp_pkg.sv
design/cstp_if.sv
design/c_style_integer_text_parser.sv
test/tb_c_style_integer_text_parser.sv
